// ===== src/evest_pkg.sv =====
// Shared constants for the encoder velocity estimator.
`default_nettype none
package evest_pkg;

  // Parameter defaults
  localparam int COUNT_W_DEF = 32;
  localparam int TIME_W_DEF  = 32;

  // Field widths
  localparam int OUT_W  = 48;
  localparam int PPR_W  = 16;
  localparam int U_W    = 25;   // angle units per revolution, Q16
  localparam int US_W   = 20;   // width of one million
  localparam int LO_W   = 29;   // split point of the scaled delta
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Angle units per revolution in Q16
  localparam logic [U_W-1:0]  DEG_PER_REV_Q16 = 25'd23592960;
  localparam logic [U_W-1:0]  RAD_PER_REV_Q16 = 25'd411775;
  localparam logic [US_W-1:0] US_PER_SECOND   = 20'd1000000;

  // Saturation limits
  localparam logic [OUT_W-1:0] VEL_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] VEL_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Item modes
  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_ZERO   = 2'd1;
  localparam logic [1:0] MODE_PRESET = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_USE_DEGREES   = 2'd0;
  localparam logic [1:0] REG_PULSES_PER_REV = 2'd1;
  localparam logic [1:0] REG_STALL_TIMEOUT = 2'd2;

  // Register reset values
  localparam logic [PPR_W-1:0] PPR_RESET   = 16'd2400;
  localparam logic [31:0]      STALL_RESET = 32'd100000;

endpackage
`default_nettype wire

// ===== src/encoder_velocity_estimator.sv =====
// Encoder velocity estimator: period-based shaft speed from counts and timestamps.
//
// Input channel (in_valid_i/in_ready_o) carries one sample per transfer: a mode,
// the encoder count, a microsecond timestamp and a preset count. Output channel
// (out_valid_o/out_ready_i) returns one result per sample: Q31.16 velocity in
// degrees or radians per second, saturated to 48 bits, and a moved flag.
// Configuration goes through an APB-style port: angle unit select at 0x0,
// counts per revolution at 0x4, stall timeout at 0x8. pready is tied high.
// Zero, preset and unknown modes, a zero count delta and a stall go from idle
// straight to the done state, which fills the output register once it is free.
// Any other update runs one shared multiplier over four steps (delta*unit, two
// halves of *1e6, pulses*dt), then a restoring divider that yields one quotient
// bit per cycle for all 48 quotient bits, then a rounding step. A zero divisor or
// a quotient past 48 bits skips the divider and saturates. in_ready_o is high only
// while the sequencer is idle, so one sample is in work at a time.
// A finished result sits in the output register; the next sample is taken
// while it waits, and its own result waits in the sequencer until the output
// register is free. Reset clears the marks, the held velocity and both
// channels, and restores the register defaults.
`default_nettype none
module encoder_velocity_estimator #(
  parameter int COUNT_WIDTH = evest_pkg::COUNT_W_DEF,
  parameter int TIME_WIDTH  = evest_pkg::TIME_W_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input samples
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [31:0]                  position_count_i,
  input  logic [31:0]                         timestamp_us_i,
  input  logic signed [31:0]                  preset_count_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [evest_pkg::OUT_W-1:0]  velocity_q16_o,
  output logic                                moved_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [evest_pkg::ADDR_W-1:0]        paddr,
  input  logic [evest_pkg::DATA_W-1:0]        pwdata,
  output logic [evest_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);
  import evest_pkg::*;

  localparam int MAG_W = COUNT_WIDTH + 1;
  localparam int MA_W  = (MAG_W > LO_W) ? MAG_W : LO_W;
  localparam int MB_W  = (TIME_WIDTH > U_W) ? TIME_WIDTH : U_W;
  localparam int PW    = MA_W + MB_W;
  localparam int AW    = MAG_W + U_W;           // delta * unit
  localparam int HI_W  = AW - LO_W;
  localparam int NW    = AW + US_W;             // full numerator
  localparam int NH_W  = NW - OUT_W;            // numerator bits above the quotient
  localparam int DW    = PPR_W + TIME_WIDTH;    // denominator
  localparam int CNT_W = $clog2(OUT_W);

  typedef enum logic [3:0] {
    S_IDLE, S_MA, S_ML, S_MH, S_MD, S_CMP, S_DIV, S_RND, S_DONE
  } state_e;

  // ---------------- configuration registers ----------------
  logic             use_deg_q;
  logic [PPR_W-1:0] ppr_q;
  logic [31:0]      stall_q;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_deg_q <= 1'b1;
      ppr_q     <= PPR_RESET;
      stall_q   <= STALL_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_USE_DEGREES:    use_deg_q <= pwdata[0];
        REG_PULSES_PER_REV: ppr_q     <= pwdata[PPR_W-1:0];
        REG_STALL_TIMEOUT:  stall_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_USE_DEGREES:    prdata = {{(DATA_W-1){1'b0}}, use_deg_q};
      REG_PULSES_PER_REV: prdata = {{(DATA_W-PPR_W){1'b0}}, ppr_q};
      REG_STALL_TIMEOUT:  prdata = stall_q;
      default:            prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  state_e                        state_q;
  logic signed [COUNT_WIDTH-1:0] last_cnt_q, prev_cnt_q;
  logic [TIME_WIDTH-1:0]         last_t_q, prev_t_q;
  logic [OUT_W-1:0]              hold_q;

  // working registers
  logic [MAG_W-1:0]  mag_q;
  logic              neg_q;
  logic              moved_q;
  logic [TIME_WIDTH-1:0] dt_q;
  logic [PW-1:0]     prod_q;
  logic [AW-1:0]     a_q;
  logic [NW-1:0]     num_q;
  logic [DW-1:0]     den_q;
  logic [DW-1:0]     rem_q;
  logic [OUT_W-1:0]  quo_q;       // low numerator bits shift out, quotient bits in
  logic [CNT_W-1:0]  cnt_q;
  logic [OUT_W-1:0]  res_q;

  // output register
  logic              ovalid_q;
  logic [OUT_W-1:0]  ovel_q;
  logic              omoved_q;

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = ovalid_q;
  assign velocity_q16_o = ovel_q;
  assign moved_o        = omoved_q;

  // ---------------- sample decode ----------------
  logic signed [COUNT_WIDTH-1:0] cur_cnt, pre_cnt;
  logic [TIME_WIDTH-1:0]         now_t, dt1, dt2;
  logic                          cnt_moved, stalled;
  logic signed [MAG_W-1:0]       delta;
  logic [MAG_W-1:0]              delta_mag;

  assign cur_cnt   = position_count_i[COUNT_WIDTH-1:0];
  assign pre_cnt   = preset_count_i[COUNT_WIDTH-1:0];
  assign now_t     = timestamp_us_i[TIME_WIDTH-1:0];
  assign dt1       = now_t - last_t_q;
  assign dt2       = now_t - prev_t_q;
  assign cnt_moved = (cur_cnt != last_cnt_q);
  assign stalled   = !cnt_moved && (32'(dt1) > stall_q);
  assign delta     = cnt_moved ? (MAG_W'(cur_cnt) - MAG_W'(last_cnt_q))
                               : (MAG_W'(cur_cnt) - MAG_W'(prev_cnt_q));
  assign delta_mag = delta[MAG_W-1] ? MAG_W'(-delta) : MAG_W'(delta);

  // ---------------- shared multiplier ----------------
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [PW-1:0]   mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MA: begin
        mul_a = MA_W'(mag_q);
        mul_b = MB_W'(use_deg_q ? DEG_PER_REV_Q16 : RAD_PER_REV_Q16);
      end
      S_ML: begin
        mul_a = MA_W'(prod_q[LO_W-1:0]);
        mul_b = MB_W'(US_PER_SECOND);
      end
      S_MH: begin
        mul_a = MA_W'(a_q[AW-1:LO_W]);
        mul_b = MB_W'(US_PER_SECOND);
      end
      S_MD: begin
        mul_a = MA_W'(ppr_q);
        mul_b = MB_W'(dt_q);
      end
      default: ;
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // ---------------- divider step and rounding ----------------
  logic [DW-1:0]    den_w;
  logic [NH_W-1:0]  num_hi;
  logic [DW:0]      rem_sh;
  logic             rem_ge;
  logic [DW:0]      rem_sub;
  logic             rnd_up;
  logic [OUT_W:0]   q_rnd;
  logic             q_ovf;
  logic [OUT_W-1:0] sat_val;
  logic             out_free;

  assign den_w   = prod_q[DW-1:0];
  assign num_hi  = num_q[NW-1:OUT_W];
  assign rem_sh  = {rem_q, quo_q[OUT_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign rnd_up  = {rem_q, 1'b0} >= {1'b0, den_q};
  assign q_rnd   = {1'b0, quo_q} + (OUT_W+1)'(rnd_up);
  // magnitude limit: 2^47-1 toward plus, 2^47 toward minus
  assign q_ovf   = neg_q ? (q_rnd > {2'b01, {(OUT_W-1){1'b0}}})
                         : (q_rnd > {2'b00, {(OUT_W-1){1'b1}}});
  assign sat_val = neg_q ? VEL_MIN : VEL_MAX;
  assign out_free = !ovalid_q || out_ready_i;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      last_cnt_q <= '0;
      prev_cnt_q <= '0;
      last_t_q   <= '0;
      prev_t_q   <= '0;
      hold_q     <= '0;
      ovalid_q   <= 1'b0;
      ovel_q     <= '0;
      omoved_q   <= 1'b0;
      mag_q      <= '0;
      neg_q      <= 1'b0;
      moved_q    <= 1'b0;
      dt_q       <= '0;
      prod_q     <= '0;
      a_q        <= '0;
      num_q      <= '0;
      den_q      <= '0;
      rem_q      <= '0;
      quo_q      <= '0;
      cnt_q      <= '0;
      res_q      <= '0;
    end else begin
      // in S_DONE the output register is refilled instead
      if (ovalid_q && out_ready_i && (state_q != S_DONE)) ovalid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (mode_i)
              MODE_UPDATE: begin
                moved_q <= cnt_moved;
                neg_q   <= delta[MAG_W-1];
                mag_q   <= delta_mag;
                dt_q    <= cnt_moved ? dt1 : dt2;
                if (cnt_moved) begin
                  prev_t_q   <= last_t_q;
                  last_t_q   <= now_t;
                  prev_cnt_q <= last_cnt_q;
                  last_cnt_q <= cur_cnt;
                end
                if (stalled || delta_mag == '0) begin
                  res_q   <= '0;
                  state_q <= S_DONE;
                end else begin
                  res_q   <= hold_q;
                  state_q <= S_MA;
                end
              end
              MODE_ZERO: begin
                moved_q    <= 1'b0;
                last_cnt_q <= '0;
                prev_cnt_q <= '0;
                res_q      <= '0;
                state_q    <= S_DONE;
              end
              MODE_PRESET: begin
                moved_q    <= 1'b0;
                last_cnt_q <= pre_cnt;
                prev_cnt_q <= pre_cnt;
                res_q      <= hold_q;
                state_q    <= S_DONE;
              end
              default: begin  // unknown mode: report the held velocity
                moved_q <= 1'b0;
                res_q   <= hold_q;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_MA: begin
          prod_q  <= mul_p;
          state_q <= S_ML;
        end
        S_ML: begin
          a_q     <= prod_q[AW-1:0];
          prod_q  <= mul_p;
          state_q <= S_MH;
        end
        S_MH: begin
          num_q   <= NW'(prod_q[LO_W+US_W-1:0]);
          prod_q  <= mul_p;
          state_q <= S_MD;
        end
        S_MD: begin
          num_q   <= num_q + (NW'(prod_q[HI_W+US_W-1:0]) << LO_W);
          prod_q  <= mul_p;
          state_q <= S_CMP;
        end
        S_CMP: begin
          den_q <= den_w;
          rem_q <= DW'(num_hi);
          quo_q <= num_q[OUT_W-1:0];
          cnt_q <= '0;
          // zero divisor, or quotient already past 48 bits
          if (den_w == '0 || {{(DW-NH_W){1'b0}}, num_hi} >= den_w) begin
            res_q   <= sat_val;
            state_q <= S_DONE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          quo_q <= {quo_q[OUT_W-2:0], rem_ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(OUT_W-1)) state_q <= S_RND;
        end
        S_RND: begin
          if (q_ovf) res_q <= sat_val;
          else res_q <= neg_q ? OUT_W'(-q_rnd) : q_rnd[OUT_W-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            ovel_q   <= res_q;
            omoved_q <= moved_q;
            hold_q   <= res_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/evest_checker.sv =====
// Port-level checks for the encoder velocity estimator, bound to the top level.
`default_nettype none
module evest_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic [1:0]                         mode_i,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic signed [evest_pkg::OUT_W-1:0] velocity_q16_o,
  input wire logic                               moved_o
);
  import evest_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(velocity_q16_o) && $stable(moved_o))
    else $error("result changed while stalled");

  // one sample in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("transfer accepted while busy");

  // zero mode reports zero velocity and no movement
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_ZERO) && !out_valid_o
    |=> ##1 out_valid_o && (velocity_q16_o == '0) && !moved_o)
    else $error("zero mode result wrong");

  // preset never reports movement
  a_preset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_PRESET) && !out_valid_o
    |=> ##1 out_valid_o && !moved_o)
    else $error("preset mode result wrong");

endmodule

bind encoder_velocity_estimator evest_checker u_evest_checker (.*);
`default_nettype wire

// ===== verif/velocity_checker.sv =====
// Checker for the encoder velocity estimator: predicts each result and compares it.
module velocity_checker
  import evest_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [1:0]              mode_i,
  input  logic signed [31:0]      position_count_i,
  input  logic [31:0]             timestamp_us_i,
  input  logic signed [31:0]      preset_count_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [OUT_W-1:0]        velocity_q16_i,
  input  logic                    moved_i,
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic [ADDR_W-1:0]       paddr_i,
  input  logic [DATA_W-1:0]       pwdata_i,
  input  logic                    pready_i,
  output int                      mismatch_count_o,
  output int                      pending_o,
  output int                      results_checked_o
);

  typedef struct packed {
    logic [OUT_W-1:0] vel;
    logic             moved;
  } speed_result_t;

  speed_result_t    speed_q[$];
  speed_result_t    want;

  // register shadows
  logic             use_deg;
  logic [PPR_W-1:0] ppr;
  logic [31:0]      stall_us;

  // marks and held velocity
  longint           mark_count;
  longint           pre_count;
  logic [31:0]      mark_time;
  logic [31:0]      pre_time;
  logic [OUT_W-1:0] held_vel;

  int               mismatches;
  int               checked;

  // Rounded, saturated delta*unit*1e6 / (ppr*span), exact in 128 bits.
  function automatic logic [OUT_W-1:0] angular_rate(longint delta, logic [31:0] span);
    logic         neg;
    logic [127:0] mag, num, den, quo, rem, limit;
    neg = (delta < 0);
    mag = neg ? 128'(-delta) : 128'(delta);
    if (mag == 0) return '0;
    den = 128'(ppr) * 128'(span);
    if (den == 0) return neg ? VEL_MIN : VEL_MAX;
    num = mag * 128'(use_deg ? DEG_PER_REV_Q16 : RAD_PER_REV_Q16) * 128'(US_PER_SECOND);
    quo = num / den;
    rem = num % den;
    if (rem >= den - rem) quo = quo + 1;  // ties go away from zero
    limit = neg ? (128'(1) << (OUT_W - 1)) : ((128'(1) << (OUT_W - 1)) - 1);
    if (quo > limit) return neg ? VEL_MIN : VEL_MAX;
    return neg ? -quo[OUT_W-1:0] : quo[OUT_W-1:0];
  endfunction

  function automatic speed_result_t predict_sample();
    longint        cur;
    logic [31:0]   since_mark, since_pre;
    speed_result_t res;
    res.moved = 1'b0;
    case (mode_i)
      MODE_UPDATE: begin
        cur        = longint'(position_count_i);
        since_mark = timestamp_us_i - mark_time;
        since_pre  = timestamp_us_i - pre_time;
        if (cur != mark_count) begin
          res.moved  = 1'b1;
          held_vel   = angular_rate(cur - mark_count, since_mark);
          pre_time   = mark_time;
          mark_time  = timestamp_us_i;
          pre_count  = mark_count;
          mark_count = cur;
        end else begin
          held_vel = angular_rate(cur - pre_count, since_pre);
          if (since_mark > stall_us) held_vel = '0;
        end
      end
      MODE_ZERO: begin
        mark_count = 0;
        pre_count  = 0;
        held_vel   = '0;
      end
      MODE_PRESET: begin
        mark_count = longint'(preset_count_i);
        pre_count  = longint'(preset_count_i);
      end
      default: ;  // unknown mode leaves everything alone
    endcase
    res.vel = held_vel;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q.delete();
      use_deg           = 1'b1;
      ppr               = PPR_RESET;
      stall_us          = STALL_RESET;
      mark_count        = 0;
      pre_count         = 0;
      mark_time         = '0;
      pre_time          = '0;
      held_vel          = '0;
      mismatches        = 0;
      checked           = 0;
      mismatch_count_o  <= 0;
      pending_o         <= 0;
      results_checked_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          {REG_USE_DEGREES, 2'b00}:    use_deg  = pwdata_i[0];
          {REG_PULSES_PER_REV, 2'b00}: ppr      = pwdata_i[PPR_W-1:0];
          {REG_STALL_TIMEOUT, 2'b00}:  stall_us = pwdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (speed_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: velocity %0d moved %0b",
                   $time, $signed(velocity_q16_i), moved_i);
        end else begin
          want = speed_q.pop_front();
          checked++;
          if (velocity_q16_i !== want.vel) begin
            mismatches++;
            $display("%0t: velocity_q16 expected %0d got %0d", $time,
                     $signed(want.vel), $signed(velocity_q16_i));
          end
          if (moved_i !== want.moved) begin
            mismatches++;
            $display("%0t: moved expected %0b got %0b", $time, want.moved, moved_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) speed_q.push_back(predict_sample());
      mismatch_count_o  <= mismatches;
      pending_o         <= speed_q.size();
      results_checked_o <= checked;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the velocity estimator testbench: clock, reset, stimulus and verdict.
module testbench;
  import evest_pkg::*;

  // Mode code the block must ignore; not part of the package.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 250;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          mode = MODE_UPDATE;
  logic signed [31:0]  position_count = '0;
  logic [31:0]         timestamp_us = '0;
  logic signed [31:0]  preset_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OUT_W-1:0]    velocity_q16;
  logic                moved;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int                  mismatches;
  int                  pending;
  int                  results_checked;

  // Stimulus bookkeeping
  bit                  gaps_on = 1'b1;     // sender inserts idle cycles
  bit                  stalls_on = 1'b1;   // receiver drops ready
  int                  samples_sent = 0;
  int                  directed_sent = 0;
  int                  settings_applied = 0;
  int                  quiet_cycles = 0;
  logic [31:0]         clock_us;           // simulated free-running microsecond timer
  int                  shaft;              // simulated encoder position

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  encoder_velocity_estimator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .mode_i           (mode),
    .position_count_i (position_count),
    .timestamp_us_i   (timestamp_us),
    .preset_count_i   (preset_count),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .velocity_q16_o   (velocity_q16),
    .moved_o          (moved),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  velocity_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .mode_i            (mode),
    .position_count_i  (position_count),
    .timestamp_us_i    (timestamp_us),
    .preset_count_i    (preset_count),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .velocity_q16_i    (velocity_q16),
    .moved_i           (moved),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .pready_i          (pready),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending),
    .results_checked_o (results_checked)
  );

  // Idle stretch: mostly a few cycles, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(40, 200);
  endfunction

  // One input transfer. Called on a rising edge; returns on the accepting edge,
  // leaving valid high so the next sample can follow back to back.
  task automatic send_sample(input logic [1:0] m, input logic [31:0] pos,
                             input logic [31:0] ts, input logic [31:0] pre);
    int gap;
    gap = (gaps_on && $urandom_range(0, 1)) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    position_count <= pos;
    timestamp_us   <= ts;
    preset_count   <= pre;
    do @(posedge clk_i); while (!in_ready);
    samples_sent++;
  endtask

  // Register write: setup, then access until pready, then the bus returns to idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Reconfigure only with the block idle. Unused upper bits carry junk.
  task automatic apply_settings(input logic deg, input logic [15:0] ppr,
                                input logic [31:0] stall);
    drain();
    write_reg(REG_USE_DEGREES, {31'($urandom), deg});
    write_reg(REG_PULSES_PER_REV, {16'($urandom), ppr});
    write_reg(REG_STALL_TIMEOUT, stall);
    settings_applied++;
  endtask

  // Random sample, mostly a plausible shaft trajectory: time moves forward,
  // the count creeps, sits still, or jumps; zero/preset/unknown modes mixed in.
  task automatic random_sample();
    int          r;
    int          step;
    logic [31:0] pre;
    r = $urandom_range(0, 99);
    if (r < 84) begin
      step = $urandom_range(0, 99);
      if (step < 5)       clock_us = clock_us;
      else if (step < 70) clock_us = clock_us + $urandom_range(1, 2000);
      else if (step < 90) clock_us = clock_us + $urandom_range(2000, 150000);
      else                clock_us = clock_us + $urandom;
      step = $urandom_range(0, 99);
      if (step < 35)      shaft = shaft;
      else if (step < 85) shaft = shaft + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 5);
      else if (step < 95) shaft = shaft + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 100000);
      else                shaft = $urandom;
      send_sample(MODE_UPDATE, shaft, clock_us, $urandom);
    end else if (r < 89) begin
      shaft = 0;
      send_sample(MODE_ZERO, $urandom, $urandom, $urandom);
    end else if (r < 94) begin
      pre   = $urandom_range(0, 9) < 7 ? 32'(shaft + int'($urandom_range(0, 20)) - 10) : $urandom;
      shaft = pre;
      send_sample(MODE_PRESET, $urandom, $urandom, pre);
    end else begin
      send_sample(MODE_UNUSED, $urandom, $urandom, $urandom);
    end
  endtask

  // Receiver: ready in short bursts broken by stalls, or always ready.
  initial begin
    wait (rst_ni);
    forever begin
      if (!stalls_on) begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready <= 1'b0;
        repeat (idle_length()) @(posedge clk_i);
      end
    end
  end

  // Watchdog: a correct block never goes this long without some transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, register defaults: degrees, 2400 counts/rev, 100 ms stall.
    send_sample(MODE_UPDATE, 32'sd0, 32'd100, $urandom);          // still, zero delta
    send_sample(MODE_UPDATE, 32'sd10, 32'd1000, $urandom);        // first move
    send_sample(MODE_UPDATE, 32'sd10, 32'd2000, $urandom);        // still, pre-last mark
    send_sample(MODE_UPDATE, 32'sd10, 32'd101000, $urandom);      // exactly at stall limit
    send_sample(MODE_UPDATE, 32'sd10, 32'd101001, $urandom);      // one past: stalled
    send_sample(MODE_UPDATE, 32'h8000_0000, 32'd101001, $urandom); // most negative count
    send_sample(MODE_UPDATE, 32'h7fff_ffff, 32'd101001, $urandom); // zero span, saturates
    send_sample(MODE_UPDATE, 32'h7fff_ffff, 32'd101001, $urandom); // zero span vs pre-last
    send_sample(MODE_ZERO, $urandom, $urandom, $urandom);
    send_sample(MODE_UPDATE, 32'sd0, 32'd101002, $urandom);       // zero delta after clear
    send_sample(MODE_PRESET, $urandom, $urandom, 32'h7fff_ffff);
    send_sample(MODE_PRESET, $urandom, $urandom, -32'sd7);
    send_sample(MODE_UPDATE, -32'sd8, 32'hffff_fff0, $urandom);
    send_sample(MODE_UPDATE, -32'sd6, 32'h0000_0010, $urandom);   // timer wraps
    send_sample(MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
    send_sample(MODE_UPDATE, -32'sd6, 32'hffff_ffff, $urandom);   // long still: stalled
    directed_sent = samples_sent;

    // Radians, one count per rev, no stall slack: exact half-way quotients.
    apply_settings(1'b0, 16'd1, 32'd0);
    send_sample(MODE_UPDATE, -32'sd5, 32'h0000_0090, $urandom);   // +tie
    send_sample(MODE_UPDATE, -32'sd6, 32'h0000_0110, $urandom);   // -tie
    send_sample(MODE_UPDATE, -32'sd6, 32'h0000_0110, $urandom);   // -tie via pre-last mark
    send_sample(MODE_UPDATE, 32'h7fff_ffff, 32'h0000_0111, $urandom); // quotient overflow
    send_sample(MODE_PRESET, $urandom, $urandom, 32'h8000_0000);
    send_sample(MODE_UPDATE, 32'h8000_0000, 32'h0000_0200, $urandom);
    send_sample(MODE_ZERO, $urandom, $urandom, $urandom);
    directed_sent = samples_sent;

    // Random part, one register setting per phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      gaps_on   = (phase != 3);
      stalls_on = (phase != 3) && (phase != 5);
      case (phase)
        0: apply_settings(1'b1, PPR_RESET, STALL_RESET);
        1: apply_settings(1'b0, 16'd1, 32'd0);
        2: apply_settings(1'b1, 16'hffff, 32'hffff_ffff);
        3: apply_settings(1'b0, 16'($urandom_range(1, 65535)), $urandom_range(0, 5000));
        4: apply_settings(1'b1, 16'($urandom_range(1, 64)), $urandom);
        5: apply_settings(1'($urandom), 16'($urandom_range(1, 65535)), $urandom);
        default: apply_settings(1'($urandom), 16'($urandom_range(1, 65535)),
                                $urandom_range(50, 3000));
      endcase
      clock_us = $urandom;
      shaft    = $urandom_range(0, 1) ? 0 : int'($urandom);
      repeat (PHASE_ITEMS) random_sample();
    end

    drain();
    repeat (100) @(posedge clk_i);

    $display("Sent %0d samples (%0d directed) under %0d register settings",
             samples_sent, directed_sent, settings_applied + 1);
    $display("Compared %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
